@@ rtl/core/lzwc_pkg.sv @@
`timescale 1ns / 1ps

package lzwc_pkg;

  // Dictionary sizing
  localparam int CODE_SPACE  = 4096;
  localparam int CODE_W      = 12;
  localparam int NCODE_W     = CODE_W + 1;
  localparam int BYTE_CODES  = 256;
  localparam int KEY_W       = CODE_W + 8;

  // Hash table: twice the code space keeps probe chains short
  localparam int TABLE_SLOTS = 2 * CODE_SPACE;
  localparam int SLOT_IDX_W  = $clog2(TABLE_SLOTS);
  localparam int EPOCH_W     = 8;

  // Output queue
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_LVL_W  = FIFO_PTR_W + 1;

  typedef logic [CODE_W-1:0]     code_t;
  typedef logic [NCODE_W-1:0]    ncode_t;
  typedef logic [KEY_W-1:0]      key_t;
  typedef logic [SLOT_IDX_W-1:0] slot_idx_t;
  typedef logic [EPOCH_W-1:0]    epoch_t;
  typedef logic [FIFO_LVL_W-1:0] fifo_lvl_t;

  localparam epoch_t    EPOCH_EMPTY = '0;
  localparam epoch_t    EPOCH_FIRST = epoch_t'(1);
  localparam epoch_t    EPOCH_LAST  = '1;
  localparam ncode_t    FIRST_CODE  = ncode_t'(BYTE_CODES);
  localparam ncode_t    CODE_CAP    = ncode_t'(CODE_SPACE);
  localparam slot_idx_t SLOT_LAST   = '1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE
  } dict_state_t;

  // One hash table slot
  typedef struct packed {
    epoch_t epoch;
    key_t   key;
    code_t  code;
  } slot_t;

  // One result item
  typedef struct packed {
    code_t code;
    logic  last;
  } result_t;

  // Up to two results per step; second implies first
  typedef struct packed {
    logic    valid0;
    result_t res0;
    logic    valid1;
    result_t res1;
  } push_t;

  // Output queue status
  typedef struct packed {
    logic      room;
    fifo_lvl_t level;
  } fifo_stat_t;

  function automatic slot_idx_t hash_idx(code_t prefix, logic [7:0] b);
    slot_idx_t h;
    h = slot_idx_t'({prefix, 1'b0}) ^ slot_idx_t'({b, 5'b0});
    return h;
  endfunction

endpackage

@@ rtl/core/lzwc_out_fifo.sv @@
`timescale 1ns / 1ps

module lzwc_out_fifo import lzwc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  push_t      push,
  output fifo_stat_t stat,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_res
);

  result_t                slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr;
  logic [FIFO_PTR_W-1:0]  rd_ptr;
  fifo_lvl_t              level;
  fifo_lvl_t              level_next;
  logic                   pop;
  fifo_lvl_t              n_push;

  assign pop       = out_valid && out_ready;
  assign out_valid = (level != '0);
  assign out_res   = slots[rd_ptr];
  assign n_push    = fifo_lvl_t'(push.valid0) + fifo_lvl_t'(push.valid1);
  assign level_next = level + n_push - fifo_lvl_t'(pop);

  // Room for the two results one byte can cause
  assign stat.room  = (level <= fifo_lvl_t'(FIFO_DEPTH - 2));
  assign stat.level = level;

  // Advance pointers and level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[FIFO_PTR_W-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level_next;
    end
  end

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push.valid0) begin
      slots[wr_ptr] <= push.res0;
    end
    if (push.valid1) begin
      slots[wr_ptr + 1'b1] <= push.res1;
    end
  end

endmodule

@@ rtl/core/lzwc_dict.sv @@
`timescale 1ns / 1ps

module lzwc_dict import lzwc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ncode_t     code_limit,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  fifo_stat_t fifo_stat,
  output push_t      push
);

  // Hash table memory
  slot_t       table_mem [TABLE_SLOTS];
  slot_t       rd_data;
  logic        rd_en;
  slot_idx_t   rd_addr;
  logic        wr_en;
  slot_idx_t   wr_addr;
  slot_t       wr_data;

  dict_state_t state, state_next;
  slot_idx_t   clr_idx, clr_idx_next;
  slot_idx_t   probe_idx, probe_idx_next;
  epoch_t      epoch, epoch_next;
  ncode_t      next_code, next_code_next;
  code_t       prefix_code, prefix_code_next;
  logic        have_prefix, have_prefix_next;
  logic [7:0]  cur_byte, cur_byte_next;
  logic        cur_last, cur_last_next;

  logic        accept;
  key_t        probe_key;
  logic        slot_hit;
  logic        slot_free;
  logic        end_msg;

  assign in_ready  = (state == ST_IDLE) && fifo_stat.room;
  assign accept    = in_valid && in_ready;
  assign probe_key = {prefix_code, cur_byte};
  assign slot_hit  = (rd_data.epoch == epoch) && (rd_data.key == probe_key);
  assign slot_free = (rd_data.epoch != epoch);

  // Message ends on an accepted last byte, or on a resolved probe for one
  always_comb begin
    end_msg = 1'b0;
    if (state == ST_IDLE) begin
      end_msg = accept && !have_prefix && in_last;
    end else if (state == ST_PROBE) begin
      end_msg = cur_last && (slot_hit || slot_free);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == SLOT_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && have_prefix) begin
          state_next = ST_PROBE;
        end else if (end_msg && epoch == EPOCH_LAST) begin
          state_next = ST_CLEAR;
        end
      end
      ST_PROBE: begin
        if (slot_hit || slot_free) begin
          if (end_msg && epoch == EPOCH_LAST) begin
            state_next = ST_CLEAR;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath, memory controls and result pushes
  always_comb begin
    clr_idx_next     = clr_idx;
    probe_idx_next   = probe_idx;
    epoch_next       = epoch;
    next_code_next   = next_code;
    prefix_code_next = prefix_code;
    have_prefix_next = have_prefix;
    cur_byte_next    = cur_byte;
    cur_last_next    = cur_last;
    rd_en            = 1'b0;
    rd_addr          = probe_idx;
    wr_en            = 1'b0;
    wr_addr          = probe_idx;
    wr_data          = '{epoch: epoch, key: probe_key, code: next_code[CODE_W-1:0]};
    push             = '0;

    unique case (state)
      ST_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_idx;
        wr_data      = '{epoch: EPOCH_EMPTY, key: '0, code: '0};
        clr_idx_next = clr_idx + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          cur_byte_next = in_byte;
          cur_last_next = in_last;
          if (!have_prefix) begin
            // First byte starts the prefix
            prefix_code_next = code_t'(in_byte);
            have_prefix_next = 1'b1;
            if (in_last) begin
              push.valid0 = 1'b1;
              push.res0   = '{code: code_t'(in_byte), last: 1'b1};
            end
          end else begin
            // Launch the first probe
            rd_en          = 1'b1;
            rd_addr        = hash_idx(prefix_code, in_byte);
            probe_idx_next = hash_idx(prefix_code, in_byte);
          end
        end
      end
      ST_PROBE: begin
        if (slot_hit) begin
          prefix_code_next = rd_data.code;
          if (cur_last) begin
            push.valid0 = 1'b1;
            push.res0   = '{code: rd_data.code, last: 1'b1};
          end
        end else if (slot_free) begin
          // Miss: emit prefix, learn the string, restart from the byte
          push.valid0 = 1'b1;
          push.res0   = '{code: prefix_code, last: 1'b0};
          if (cur_last) begin
            push.valid1 = 1'b1;
            push.res1   = '{code: code_t'(cur_byte), last: 1'b1};
          end
          if (next_code < code_limit) begin
            wr_en          = 1'b1;
            next_code_next = next_code + 1'b1;
          end
          prefix_code_next = code_t'(cur_byte);
        end else begin
          // Collision: try the next slot
          rd_en          = 1'b1;
          rd_addr        = probe_idx + 1'b1;
          probe_idx_next = probe_idx + 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Forget learned strings at the end of a message
    if (end_msg) begin
      next_code_next   = FIRST_CODE;
      prefix_code_next = '0;
      have_prefix_next = 1'b0;
      clr_idx_next     = '0;
      epoch_next       = (epoch == EPOCH_LAST) ? EPOCH_FIRST : epoch + 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_idx     <= '0;
      epoch       <= EPOCH_FIRST;
      next_code   <= FIRST_CODE;
      prefix_code <= '0;
      have_prefix <= 1'b0;
    end else begin
      state       <= state_next;
      clr_idx     <= clr_idx_next;
      epoch       <= epoch_next;
      next_code   <= next_code_next;
      prefix_code <= prefix_code_next;
      have_prefix <= have_prefix_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    probe_idx <= probe_idx_next;
    cur_byte  <= cur_byte_next;
    cur_last  <= cur_last_next;
  end

  // Table write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= table_mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/lzw_byte_compressor_unit.sv @@
`timescale 1ns / 1ps

// Byte-oriented LZW compressor. Each input transfer carries one byte in
// s_axis_tdata and marks the final byte of a message with s_axis_tlast; each
// output transfer carries one 12-bit code, the final code of a message flagged
// by m_axis_tlast. Learned strings live in an 8192-slot hash table (one
// synchronous RAM, linear probing, slots tagged with a message epoch). A byte
// that continues a message is looked up, probing the next slot per hash
// collision. After reset, and after every 255th message, the table is swept
// clear, and no byte is accepted meanwhile; codes are capped at 4096. max_codes
// is set through cfg_wr_en/cfg_wr_data; the user must write it only while the
// block is idle, which the block does not enforce. Results queue in a 4-entry
// output FIFO, so input is taken while earlier codes wait for the sink.

module lzw_byte_compressor_unit import lzwc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data,   // max_codes
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] byte_in
  input  logic        s_axis_tlast,  // last_byte
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [11:0] code_out, [15:12] zero
  output logic        m_axis_tlast   // last_code
);

  ncode_t     max_codes;
  ncode_t     code_limit;
  push_t      push;
  fifo_stat_t fifo_stat;
  result_t    out_res;

  // Hold the code limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_codes <= CODE_CAP;
    end else if (cfg_wr_en) begin
      max_codes <= cfg_wr_data;
    end
  end

  // Saturate the limit to the code space
  assign code_limit = (max_codes > CODE_CAP) ? CODE_CAP : max_codes;

  lzwc_dict u_dict (
    .clk        (clk),
    .rst        (rst),
    .code_limit (code_limit),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .fifo_stat  (fifo_stat),
    .push       (push)
  );

  lzwc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .stat      (fifo_stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {4'b0, out_res.code};
  assign m_axis_tlast = out_res.last;

`ifndef SYNTH
  // Queue never overfills
  assert property (@(posedge clk) disable iff (rst)
    fifo_stat.level <= fifo_lvl_t'(FIFO_DEPTH))
    else $error("output queue level above depth");

  // A single push lands only where a slot is free
  assert property (@(posedge clk) disable iff (rst)
    push.valid0 |-> (fifo_stat.level <= fifo_lvl_t'(FIFO_DEPTH - 1)))
    else $error("result pushed into a full queue");

  // A double push lands only where two slots are free
  assert property (@(posedge clk) disable iff (rst)
    push.valid1 |-> (push.valid0 && fifo_stat.level <= fifo_lvl_t'(FIFO_DEPTH - 2)))
    else $error("second result pushed without room");
`endif

endmodule
